// ===== hdl/rcb_pkg.sv =====
package rcb_pkg;

	// Q1.16 value of one
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// input actions
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_COLOR = 2'd1,
		ACT_START = 2'd2,
		ACT_CUT   = 2'd3
	} rcb_action_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ALPHA_OFFSET = 2'd0,
		REG_MASTER_ALPHA = 2'd1,
		REG_BLEND_STEP   = 2'd2
	} rcb_reg_t;

	// load enables of the lane pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} rcb_stage_en_t;

	// alpha plus signed offset, clamped to 0..255
	function automatic logic [7:0] clamp_alpha(input logic [7:0] a, input logic signed [8:0] off);
		logic signed [9:0] sum;
		logic [7:0]        res;
		sum = $signed({2'b00, a}) + $signed({off[8], off});
		if (sum < 10'sd0)
			res = 8'd0;
		else if (sum > 10'sd255)
			res = 8'd255;
		else
			res = sum[7:0];
		return res;
	endfunction

endpackage

// ===== hdl/rcb_fade.sv =====
module rcb_fade import rcb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  action,
	input  logic [16:0] blend_step,
	output logic [16:0] fraction,
	output logic        active_next
);

	logic [16:0] fraction_q;
	logic [16:0] fraction_d;
	logic [17:0] sum;

	assign fraction = fraction_q;

	// next blend fraction for the action in transfer
	always_comb begin
		sum = {1'b0, fraction_q} + {1'b0, blend_step};
		fraction_d = fraction_q;
		unique case (rcb_action_t'(action))
			ACT_TICK: begin
				if (fraction_q < ONE_Q16)
					fraction_d = (sum > {1'b0, ONE_Q16}) ? ONE_Q16 : sum[16:0];
			end
			ACT_COLOR: fraction_d = fraction_q;
			ACT_START: fraction_d = '0;
			ACT_CUT:   fraction_d = ONE_Q16;
			default:   fraction_d = fraction_q;
		endcase
	end

	assign active_next = (fraction_d < ONE_Q16);

	// fraction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fraction_q <= ONE_Q16;
		else if (accept)
			fraction_q <= fraction_d;
	end

endmodule

// ===== hdl/rcb_lane.sv =====
module rcb_lane import rcb_pkg::*; (
	input  logic          clk,
	input  rcb_stage_en_t en,
	input  logic [7:0]    cur,
	input  logic [7:0]    prev,
	input  logic [16:0]   fraction_s1,
	input  logic [7:0]    master_alpha,
	output logic [7:0]    ch_s4
);

	logic [7:0]  cur_s1;
	logic [7:0]  prev_s1;
	logic [7:0]  blend_s2;
	logic [15:0] prod_s3;
	logic [24:0] mix;
	logic [16:0] inv;
	logic [16:0] div_sum;

	// stage 1: channel capture
	always_ff @(posedge clk) begin
		if (en.s1) begin
			cur_s1  <= cur;
			prev_s1 <= prev;
		end
	end

	// stage 2: linear cross-fade, truncated
	always_comb begin
		inv = ONE_Q16 - fraction_s1;
		mix = 25'({8'd0, fraction_s1} * {17'd0, cur_s1}) + 25'({8'd0, inv} * {17'd0, prev_s1});
	end

	always_ff @(posedge clk) begin
		if (en.s2)
			blend_s2 <= mix[23:16];
	end

	// stage 3: intensity product
	always_ff @(posedge clk) begin
		if (en.s3)
			prod_s3 <= {8'd0, blend_s2} * {8'd0, master_alpha};
	end

	// stage 4: exact divide by 255 for products of two bytes
	assign div_sum = {1'b0, prod_s3} + 17'd1 + {9'd0, prod_s3[15:8]};

	always_ff @(posedge clk) begin
		if (en.s4)
			ch_s4 <= div_sum[15:8];
	end

endmodule

// ===== hdl/rgba_crossfade_blender.sv =====
// RGBA8 cross-fade blender. Each transfer carries an action: a color pair gets its two alphas
// offset and clamped, every channel cross-faded from the previous color to the current one by
// the Q1.16 blend fraction and then scaled by master_alpha/255 (truncating); tick advances the
// fraction by blend_step up to one, start sets it to zero, cut to one. Every action returns one
// result, out_color being zero for all but color pairs, with fade_active taken after the action.
// One item is accepted every clock while in_stall is low; a result is offered from the last of
// the four register stages of the four channel lanes (capture at the transfer edge, cross-fade
// multiply, intensity multiply, divide by 255). Stalls hold only the stages behind a full one,
// so bubbles are squeezed out. Configuration writes are always ready.
module rgba_crossfade_blender import rcb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] current_color,
	input  logic [31:0] previous_color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_color,
	output logic        fade_active,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	logic [8:0]    alpha_offset_q;
	logic [7:0]    master_alpha_q;
	logic [16:0]   blend_step_q;
	logic          in_accept;
	logic [16:0]   fraction;
	logic          active_next;
	rcb_stage_en_t en;
	logic          valid_s1, valid_s2, valid_s3, valid_s4;
	logic          color_s1, color_s2, color_s3, color_s4;
	logic          active_s1, active_s2, active_s3, active_s4;
	logic [16:0]   fraction_s1;
	logic [31:0]   cur_in;
	logic [31:0]   prev_in;
	logic [31:0]   packed_s4;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_offset_q <= '0;
			master_alpha_q <= 8'hff;
			blend_step_q   <= ONE_Q16;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rcb_reg_t'(cfg_index))
				REG_ALPHA_OFFSET: alpha_offset_q <= cfg_data[8:0];
				REG_MASTER_ALPHA: master_alpha_q <= cfg_data[7:0];
				REG_BLEND_STEP:   blend_step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when the one after it moves on
	always_comb begin
		en.s4 = !valid_s4 || !out_stall;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign in_stall  = !en.s1;
	assign in_accept = in_valid && !in_stall;

	// blend fraction state
	rcb_fade u_fade (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.action      (action),
		.blend_step  (blend_step_q),
		.fraction    (fraction),
		.active_next (active_next)
	);

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			color_s1    <= (rcb_action_t'(action) == ACT_COLOR);
			active_s1   <= active_next;
			fraction_s1 <= fraction;
		end
		if (en.s2) begin
			color_s2  <= color_s1;
			active_s2 <= active_s1;
		end
		if (en.s3) begin
			color_s3  <= color_s2;
			active_s3 <= active_s2;
		end
		if (en.s4) begin
			color_s4  <= color_s3;
			active_s4 <= active_s3;
		end
	end

	// alpha clamp ahead of the lanes
	assign cur_in  = {clamp_alpha(current_color[31:24], alpha_offset_q), current_color[23:0]};
	assign prev_in = {clamp_alpha(previous_color[31:24], alpha_offset_q), previous_color[23:0]};

	// one lane per channel
	for (genvar i = 0; i < 4; i++) begin : g_lane
		rcb_lane u_lane (
			.clk          (clk),
			.en           (en),
			.cur          (cur_in[8*i +: 8]),
			.prev         (prev_in[8*i +: 8]),
			.fraction_s1  (fraction_s1),
			.master_alpha (master_alpha_q),
			.ch_s4        (packed_s4[8*i +: 8])
		);
	end

	// merge lanes into the result
	assign out_valid   = valid_s4;
	assign out_color   = color_s4 ? packed_s4 : 32'd0;
	assign fade_active = active_s4;

endmodule

// ===== bench/rgba_crossfade_blender_tb.sv =====
`timescale 1ns / 1ps

module rgba_crossfade_blender_tb;
	import rcb_pkg::*;

	// one expected result transfer
	typedef struct packed {
		logic [31:0] color;
		logic        fade;
	} crossfade_result_t;

	// predicts the blender and checks its results in order
	class crossfade_scoreboard;
		logic signed [8:0] alpha_offset;
		logic [7:0]        master_alpha;
		logic [16:0]       blend_step;
		logic [16:0]       fraction;
		crossfade_result_t expected_pixels[$];
		int                mismatches;
		int                results;
		int                faded_colors;

		function new();
			alpha_offset = '0;
			master_alpha = 8'hff;
			blend_step = ONE_Q16;
			fraction = ONE_Q16;
			mismatches = 0;
			results = 0;
			faded_colors = 0;
		endfunction

		function void set_register(rcb_reg_t idx, logic [16:0] data);
			case (idx)
				REG_ALPHA_OFFSET: alpha_offset = data[8:0];
				REG_MASTER_ALPHA: master_alpha = data[7:0];
				REG_BLEND_STEP:   blend_step = data;
				default: ;
			endcase
		endfunction

		// alpha plus signed offset, clamped to a byte
		function logic [7:0] offset_alpha(logic [7:0] a);
			int av;
			int ov;
			av = int'(a);
			ov = int'(alpha_offset);
			av = av + ov;
			if (av < 0)
				av = 0;
			if (av > 255)
				av = 255;
			return av[7:0];
		endfunction

		// cross-fade and intensity scaling of all four channels
		function logic [31:0] crossfade_pixel(logic [31:0] cur, logic [31:0] prev);
			logic [31:0] res;
			int unsigned c;
			int unsigned p;
			int unsigned v;
			int unsigned f;
			res = '0;
			f = 32'(fraction);
			for (int i = 0; i < 4; i++) begin
				c = 32'(cur[8*i +: 8]);
				p = 32'(prev[8*i +: 8]);
				if (i == 3) begin
					c = 32'(offset_alpha(c[7:0]));
					p = 32'(offset_alpha(p[7:0]));
				end
				v = c;
				if (f < ONE_Q16)
					v = (c * f + p * (32'h10000 - f)) >> 16;
				if (master_alpha != 8'hff)
					v = (v * master_alpha) / 255;
				res[8*i +: 8] = v[7:0];
			end
			return res;
		endfunction

		function void note_input(rcb_action_t act, logic [31:0] cur, logic [31:0] prev);
			crossfade_result_t r;
			logic [17:0]       sum;
			r.color = '0;
			case (act)
				ACT_TICK: begin
					if (fraction < ONE_Q16) begin
						sum = {1'b0, fraction} + {1'b0, blend_step};
						fraction = (sum > {1'b0, ONE_Q16}) ? ONE_Q16 : sum[16:0];
					end
				end
				ACT_COLOR: begin
					if (fraction < ONE_Q16)
						faded_colors++;
					r.color = crossfade_pixel(cur, prev);
				end
				ACT_START: fraction = '0;
				default:   fraction = ONE_Q16;
			endcase
			r.fade = (fraction < ONE_Q16);
			expected_pixels.push_back(r);
		endfunction

		function void report(string what, logic [31:0] exp, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch in %s: expected %h, got %h", $time, what, exp, got);
		endfunction

		function void check_result(logic [31:0] color, logic fade);
			crossfade_result_t exp;
			results++;
			if (expected_pixels.size() == 0) begin
				report("result with nothing pending", 32'h0, color);
				return;
			end
			exp = expected_pixels.pop_front();
			if (color !== exp.color)
				report("out_color", exp.color, color);
			if (fade !== exp.fade)
				report("fade_active", {31'h0, exp.fade}, {31'h0, fade});
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [31:0] current_color;
	logic [31:0] previous_color;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] out_color;
	logic        fade_active;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [16:0] cfg_data;

	crossfade_scoreboard sb;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int                  items_sent = 0;
	int                  phases_run = 0;

	rgba_crossfade_blender dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.current_color  (current_color),
		.previous_color (previous_color),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_color      (out_color),
		.fade_active    (fade_active),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #10 clk = ~clk;

	// random receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// result transfer happens at the next rising edge; values are stable here
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_color, fade_active);
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// one input transfer, with an optional idle gap first
	task automatic send_item(rcb_action_t act, logic [31:0] cur, logic [31:0] prev);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		action <= act;
		current_color <= cur;
		previous_color <= prev;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		sb.note_input(act, cur, prev);
		items_sent++;
	endtask

	// one register write; cfg_valid is left high for the next one
	task automatic put_register(rcb_reg_t idx, logic [16:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		sb.set_register(idx, data);
	endtask

	// upper data bits carry junk where the register is narrower
	task automatic write_settings(logic [8:0] off, logic [7:0] ma, logic [16:0] step);
		logic [7:0] junk_off;
		logic [8:0] junk_ma;
		junk_off = 8'($urandom_range(255));
		junk_ma = 9'($urandom_range(511));
		put_register(REG_ALPHA_OFFSET, {junk_off, off});
		put_register(REG_MASTER_ALPHA, {junk_ma, ma});
		put_register(REG_BLEND_STEP, step);
		cfg_valid <= 1'b0;
	endtask

	// stop sending and let every pending result drain
	task automatic finish_phase();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_color();
		logic [31:0] c;
		c = $urandom;
		case ($urandom_range(7))
			0: c = 32'h0;
			1: c = 32'hffffffff;
			2: c[31:24] = $urandom_range(1) ? 8'hff : 8'h00;
			default: ;
		endcase
		return c;
	endfunction

	task automatic random_settings();
		logic [8:0]  off;
		logic [7:0]  ma;
		logic [16:0] step;
		case ($urandom_range(3))
			0: off = 9'h000;
			1: off = 9'h100;
			default: off = 9'($urandom_range(511));
		endcase
		case ($urandom_range(3))
			0: ma = 8'hff;
			1: ma = 8'h00;
			default: ma = 8'($urandom_range(255));
		endcase
		case ($urandom_range(9))
			0: step = 17'd0;
			1: step = 17'd1;
			2: step = ONE_Q16;
			3: step = 17'($urandom_range(65537, 131071));
			4: step = 17'd65535;
			default: step = 17'(65536 / $urandom_range(2, 64));
		endcase
		write_settings(off, ma, step);
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct <= 0;
			end
			1: begin
				send_idle_pct = 68;
				recv_stall_pct <= 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct <= 68;
			end
			default: begin
				send_idle_pct = 30;
				recv_stall_pct <= 30;
			end
		endcase
	endtask

	// mostly fade sequences (start, colors and ticks, sometimes a cut), some loose actions
	task automatic run_random_phase(int n);
		int first;
		int len;
		first = items_sent;
		while (items_sent - first < n) begin
			if ($urandom_range(99) < 80) begin
				send_item(ACT_START, rand_color(), rand_color());
				len = $urandom_range(4, 30);
				repeat (len) begin
					if ($urandom_range(99) < 70)
						send_item(ACT_COLOR, rand_color(), rand_color());
					else
						send_item(ACT_TICK, rand_color(), rand_color());
				end
				if ($urandom_range(3) == 0)
					send_item(ACT_CUT, rand_color(), rand_color());
			end else begin
				send_item(rcb_action_t'(2'($urandom_range(3))), rand_color(), rand_color());
			end
		end
		phases_run++;
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_TICK;
		current_color <= '0;
		previous_color <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ALPHA_OFFSET;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: pass-through, tick with no fade, full jump to one
		send_item(ACT_COLOR, 32'h00000000, 32'h00000000);
		send_item(ACT_COLOR, 32'hffffffff, 32'h00000000);
		send_item(ACT_TICK, 32'hffffffff, 32'hffffffff);
		send_item(ACT_START, 32'h0, 32'h0);
		send_item(ACT_COLOR, 32'hffffffff, 32'h00000000);
		send_item(ACT_COLOR, 32'h80ff4020, 32'hc0112233);
		send_item(ACT_TICK, 32'h0, 32'h0);
		send_item(ACT_CUT, 32'h0, 32'h0);
		finish_phase();

		// offset of -256, zero intensity, zero step keeps the fade running
		write_settings(9'h100, 8'h00, 17'd0);
		send_item(ACT_START, 32'h0, 32'h0);
		send_item(ACT_TICK, 32'h0, 32'h0);
		send_item(ACT_TICK, 32'h0, 32'h0);
		send_item(ACT_COLOR, 32'hffffffff, 32'hffffffff);
		send_item(ACT_CUT, 32'h0, 32'h0);
		send_item(ACT_COLOR, 32'hff00ff00, 32'h12345678);
		finish_phase();

		// largest offset, intensity just below full, tick overshoot
		write_settings(9'h0ff, 8'hfe, 17'd65535);
		send_item(ACT_START, 32'h0, 32'h0);
		send_item(ACT_TICK, 32'h0, 32'h0);
		send_item(ACT_COLOR, 32'hffffffff, 32'h00000000);
		send_item(ACT_TICK, 32'h0, 32'h0);
		send_item(ACT_COLOR, 32'h00ffffff, 32'hffffffff);
		finish_phase();

		// offset of -255, smallest nonzero intensity and step
		write_settings(9'h101, 8'h01, 17'd1);
		send_item(ACT_START, 32'h0, 32'h0);
		send_item(ACT_TICK, 32'h0, 32'h0);
		send_item(ACT_COLOR, 32'hffffffff, 32'hffffffff);
		send_item(ACT_COLOR, 32'h7f80ff01, 32'hff0080fe);
		phases_run = 4;

		for (int p = 0; p < 8; p++) begin
			finish_phase();
			random_settings();
			set_idling(p % 4);
			run_random_phase(160);
		end
		finish_phase();

		$display("%0d input transfers over %0d setting phases, %0d results checked",
			items_sent, phases_run, sb.results);
		$display("%0d colors blended mid-fade, %0d mismatches", sb.faded_colors, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
